FILE: rtl/wmmt_pkg.sv
// shared types and constants of the windowed min/max tracker
`default_nettype none

package wmmt_pkg;

	// field widths
	localparam int unsigned DATA_W = 32;
	localparam int unsigned OP_W = 2;
	localparam int unsigned FRAG_W = 7;
	// numerator of the fragmentation divide: 32-bit difference times 100
	localparam int unsigned NUM_W = DATA_W + FRAG_W;
	// one quotient bit per divide step
	localparam int unsigned DIV_STEPS = FRAG_W;
	localparam int unsigned CNT_W = $clog2(DIV_STEPS);

	localparam logic [DATA_W-1:0] WIN_LEN_RST = DATA_W'(1000);
	localparam logic [FRAG_W-1:0] FRAG_MAX = FRAG_W'(100);

	// opcodes
	localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

	// controller states
	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_ROLL  = 8'b0000_0010,
		S_UPD   = 8'b0000_0100,
		S_CLR   = 8'b0000_1000,
		S_MERGE = 8'b0001_0000,
		S_MUL   = 8'b0010_0000,
		S_DIV   = 8'b0100_0000,
		S_OUT   = 8'b1000_0000
	} state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic capture;
		logic roll;
		logic update;
		logic clear;
		logic merge;
		logic mul;
		logic div_step;
		logic load_out;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic div_last;
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/wmmt_datapath.sv
// datapath: window registers, merge logic, shift-subtract divider, output word
`default_nettype none

module wmmt_datapath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire wmmt_pkg::cmd_t                  cmd,
	output wmmt_pkg::sts_t                       sts,
	input  wire logic                            cfg_we,
	input  wire logic [wmmt_pkg::DATA_W-1:0]     cfg_wdata,
	input  wire logic [wmmt_pkg::DATA_W-1:0]     now_ms,
	input  wire logic [wmmt_pkg::DATA_W-1:0]     level_a,
	input  wire logic [wmmt_pkg::DATA_W-1:0]     level_b,
	input  wire logic [wmmt_pkg::DATA_W-1:0]     largest_block,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic [wmmt_pkg::DATA_W-1:0]          band_a_min,
	output logic [wmmt_pkg::DATA_W-1:0]          band_a_max,
	output logic [wmmt_pkg::DATA_W-1:0]          band_b_min,
	output logic [wmmt_pkg::DATA_W-1:0]          band_b_max,
	output logic [wmmt_pkg::FRAG_W-1:0]          frag_pct
);

	localparam int unsigned DW = wmmt_pkg::DATA_W;
	localparam int unsigned NW = wmmt_pkg::NUM_W;
	localparam int unsigned FW = wmmt_pkg::FRAG_W;
	localparam int unsigned CW = wmmt_pkg::CNT_W;

	logic [DW-1:0] len_q;
	logic [DW-1:0] now_q, a_q, b_q, lg_q;
	logic          cur_valid_q, prev_valid_q;
	logic [DW-1:0] cur_a_min_q, cur_a_max_q, cur_b_min_q, cur_b_max_q;
	logic [DW-1:0] prev_a_min_q, prev_a_max_q, prev_b_min_q, prev_b_max_q;
	logic [DW-1:0] ws_q;
	logic [DW-1:0] m_a_min_q, m_a_max_q, m_b_min_q, m_b_max_q;
	logic [DW-1:0] diff_q;
	logic          zero_q;
	logic [NW-1:0] rem_q, dvs_q;
	logic [FW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          out_valid_q;
	logic [DW-1:0] o_a_min_q, o_a_max_q, o_b_min_q, o_b_max_q;
	logic [FW-1:0] o_frag_q;

	logic [DW-1:0] ws_eff, elapsed;
	logic          roll_hit;
	logic [DW-1:0] base_a_min, base_a_max, base_b_min, base_b_max;
	logic [DW-1:0] mrg_a_min, mrg_a_max, mrg_b_min, mrg_b_max;
	logic [NW-1:0] diff_ext, num100;
	logic [NW:0]   trial;

	// window length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= wmmt_pkg::WIN_LEN_RST;
		end else if (cfg_we) begin
			len_q <= cfg_wdata;
		end
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			now_q <= now_ms;
			a_q <= level_a;
			b_q <= level_b;
			lg_q <= largest_block;
		end
	end

	// rollover test, an unstarted window starts at the sample time
	assign ws_eff = (ws_q == '0) ? now_q : ws_q;
	assign elapsed = now_q - ws_eff;
	assign roll_hit = (elapsed >= len_q);

	// window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			prev_valid_q <= 1'b0;
			cur_a_min_q <= '0;
			cur_a_max_q <= '0;
			cur_b_min_q <= '0;
			cur_b_max_q <= '0;
			prev_a_min_q <= '0;
			prev_a_max_q <= '0;
			prev_b_min_q <= '0;
			prev_b_max_q <= '0;
			ws_q <= '0;
		end else if (cmd.clear) begin
			cur_valid_q <= 1'b0;
			prev_valid_q <= 1'b0;
			cur_a_min_q <= '0;
			cur_a_max_q <= '0;
			cur_b_min_q <= '0;
			cur_b_max_q <= '0;
			prev_a_min_q <= '0;
			prev_a_max_q <= '0;
			prev_b_min_q <= '0;
			prev_b_max_q <= '0;
			ws_q <= now_q;
		end else if (cmd.roll) begin
			if (roll_hit) begin
				if (cur_valid_q) begin
					prev_valid_q <= 1'b1;
					prev_a_min_q <= cur_a_min_q;
					prev_a_max_q <= cur_a_max_q;
					prev_b_min_q <= cur_b_min_q;
					prev_b_max_q <= cur_b_max_q;
				end
				cur_valid_q <= 1'b0;
				cur_a_min_q <= '0;
				cur_a_max_q <= '0;
				cur_b_min_q <= '0;
				cur_b_max_q <= '0;
				ws_q <= now_q;
			end else begin
				ws_q <= ws_eff;
			end
		end else if (cmd.update) begin
			cur_valid_q <= 1'b1;
			if (!cur_valid_q) begin
				cur_a_min_q <= a_q;
				cur_a_max_q <= a_q;
				cur_b_min_q <= b_q;
				cur_b_max_q <= b_q;
			end else begin
				if (a_q < cur_a_min_q) cur_a_min_q <= a_q;
				if (a_q > cur_a_max_q) cur_a_max_q <= a_q;
				if (b_q < cur_b_min_q) cur_b_min_q <= b_q;
				if (b_q > cur_b_max_q) cur_b_max_q <= b_q;
			end
		end
	end

	// merge current and last windows, then fold in the present levels
	always_comb begin
		if (cur_valid_q && prev_valid_q) begin
			base_a_min = (prev_a_min_q < cur_a_min_q) ? prev_a_min_q : cur_a_min_q;
			base_a_max = (prev_a_max_q > cur_a_max_q) ? prev_a_max_q : cur_a_max_q;
			base_b_min = (prev_b_min_q < cur_b_min_q) ? prev_b_min_q : cur_b_min_q;
			base_b_max = (prev_b_max_q > cur_b_max_q) ? prev_b_max_q : cur_b_max_q;
		end else if (cur_valid_q) begin
			base_a_min = cur_a_min_q;
			base_a_max = cur_a_max_q;
			base_b_min = cur_b_min_q;
			base_b_max = cur_b_max_q;
		end else if (prev_valid_q) begin
			base_a_min = prev_a_min_q;
			base_a_max = prev_a_max_q;
			base_b_min = prev_b_min_q;
			base_b_max = prev_b_max_q;
		end else begin
			base_a_min = a_q;
			base_a_max = a_q;
			base_b_min = b_q;
			base_b_max = b_q;
		end
		mrg_a_min = (a_q < base_a_min) ? a_q : base_a_min;
		mrg_a_max = (a_q > base_a_max) ? a_q : base_a_max;
		mrg_b_min = (b_q < base_b_min) ? b_q : base_b_min;
		mrg_b_max = (b_q > base_b_max) ? b_q : base_b_max;
	end

	// times 100 as shifts and adds: 64 + 32 + 4
	assign diff_ext = NW'(diff_q);
	assign num100 = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);

	// restoring divide step, borrow in the top bit
	assign trial = {1'b0, rem_q} - {1'b0, dvs_q};

	// merged bands, numerator and divider
	always_ff @(posedge clk) begin
		if (cmd.merge) begin
			m_a_min_q <= mrg_a_min;
			m_a_max_q <= mrg_a_max;
			m_b_min_q <= mrg_b_min;
			m_b_max_q <= mrg_b_max;
			diff_q <= a_q - lg_q;
			zero_q <= (a_q == '0) || (lg_q > a_q);
		end
		if (cmd.mul) begin
			rem_q <= num100;
			dvs_q <= {1'b0, a_q, 6'b0};
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (!trial[NW]) begin
				rem_q <= trial[NW-1:0];
			end
			dvs_q <= dvs_q >> 1;
			quo_q <= {quo_q[FW-2:0], ~trial[NW]};
		end
	end

	// step counter, counts down to the last quotient bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.mul) begin
			cnt_q <= CW'(wmmt_pkg::DIV_STEPS - 1);
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			o_a_min_q <= m_a_min_q;
			o_a_max_q <= m_a_max_q;
			o_b_min_q <= m_b_min_q;
			o_b_max_q <= m_b_max_q;
			o_frag_q <= zero_q ? '0 : quo_q;
		end
	end

	assign sts.div_last = (cnt_q == '0);
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign band_a_min = o_a_min_q;
	assign band_a_max = o_a_max_q;
	assign band_b_min = o_b_min_q;
	assign band_b_max = o_b_max_q;
	assign frag_pct = o_frag_q;

	// a valid window never has min above max
	a_cur_order: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q |-> (cur_a_min_q <= cur_a_max_q) && (cur_b_min_q <= cur_b_max_q))
		else $error("current window min above max");

	a_prev_order: assert property (@(posedge clk) disable iff (!arst_n)
		prev_valid_q |-> (prev_a_min_q <= prev_a_max_q) && (prev_b_min_q <= prev_b_max_q))
		else $error("last window min above max");

	// the divider never yields more than 100 percent
	a_frag_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (o_frag_q <= wmmt_pkg::FRAG_MAX))
		else $error("fragmentation percent out of range");

	// a new word is never loaded over one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !sts.out_busy)
		else $error("output word overwritten");

endmodule

`default_nettype wire

FILE: rtl/wmmt_ctrl.sv
// controller: state machine sequencing sample, clear and query words
`default_nettype none

module wmmt_ctrl (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [wmmt_pkg::OP_W-1:0]     opcode,
	input  wire wmmt_pkg::sts_t                sts,
	output wmmt_pkg::cmd_t                     cmd
);

	wmmt_pkg::state_t state_q, state_d;
	logic             accept;

	assign in_ready = (state_q == wmmt_pkg::S_IDLE);
	assign accept = in_valid && in_ready;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.capture = accept;
		unique case (state_q)
			wmmt_pkg::S_IDLE: begin
				if (accept) begin
					unique case (opcode)
						wmmt_pkg::OP_SAMPLE: state_d = wmmt_pkg::S_ROLL;
						wmmt_pkg::OP_QUERY: state_d = wmmt_pkg::S_MERGE;
						wmmt_pkg::OP_CLEAR: state_d = wmmt_pkg::S_CLR;
						default: state_d = wmmt_pkg::S_IDLE;
					endcase
				end
			end
			wmmt_pkg::S_ROLL: begin
				cmd.roll = 1'b1;
				state_d = wmmt_pkg::S_UPD;
			end
			wmmt_pkg::S_UPD: begin
				cmd.update = 1'b1;
				state_d = wmmt_pkg::S_IDLE;
			end
			wmmt_pkg::S_CLR: begin
				cmd.clear = 1'b1;
				state_d = wmmt_pkg::S_IDLE;
			end
			wmmt_pkg::S_MERGE: begin
				cmd.merge = 1'b1;
				state_d = wmmt_pkg::S_MUL;
			end
			wmmt_pkg::S_MUL: begin
				cmd.mul = 1'b1;
				state_d = wmmt_pkg::S_DIV;
			end
			wmmt_pkg::S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = wmmt_pkg::S_OUT;
				end
			end
			wmmt_pkg::S_OUT: begin
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = wmmt_pkg::S_IDLE;
				end
			end
			default: state_d = wmmt_pkg::S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wmmt_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a query word goes straight to the merge step
	a_query_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (opcode == wmmt_pkg::OP_QUERY)) |=> (state_q == wmmt_pkg::S_MERGE))
		else $error("query did not start merge");

	// a sample always updates right after its rollover check
	a_sample_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == wmmt_pkg::S_ROLL) |=> (state_q == wmmt_pkg::S_UPD))
		else $error("sample update skipped");

	// exactly one state bit set
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("controller state not one-hot");

endmodule

`default_nettype wire

FILE: rtl/windowed_min_max_tracker_unit.sv
// top level of the windowed min/max tracker
//
// channel   direction  handshake            payload
// in        input      in_valid/in_ready    opcode, now_ms, level_a, level_b, largest_block
// out       output     out_valid/out_ready  band_a_min/max, band_b_min/max, frag_pct
// cfg       input      cfg_we               cfg_wdata (window length in ms)
//
// a sample passes accept, rollover check and update, a clear passes accept and clear,
// a query passes accept, merge, multiply by 100, 7 divide steps and output load.
// the query time is set by the shift-subtract divider, one quotient bit a cycle.
// a query result waits in the output register; new words are accepted meanwhile,
// but a later query holds in its last step until that register is taken.
// asynchronous active-low reset clears windows and sets window length to 1000.
`default_nettype none

module windowed_min_max_tracker_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [wmmt_pkg::DATA_W-1:0]   cfg_wdata,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [wmmt_pkg::OP_W-1:0]     opcode,
	input  wire logic [wmmt_pkg::DATA_W-1:0]   now_ms,
	input  wire logic [wmmt_pkg::DATA_W-1:0]   level_a,
	input  wire logic [wmmt_pkg::DATA_W-1:0]   level_b,
	input  wire logic [wmmt_pkg::DATA_W-1:0]   largest_block,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [wmmt_pkg::DATA_W-1:0]        band_a_min,
	output logic [wmmt_pkg::DATA_W-1:0]        band_a_max,
	output logic [wmmt_pkg::DATA_W-1:0]        band_b_min,
	output logic [wmmt_pkg::DATA_W-1:0]        band_b_max,
	output logic [wmmt_pkg::FRAG_W-1:0]        frag_pct
);

	wmmt_pkg::cmd_t cmd;
	wmmt_pkg::sts_t sts;

	// controller
	wmmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.opcode   (opcode),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	wmmt_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.now_ms        (now_ms),
		.level_a       (level_a),
		.level_b       (level_b),
		.largest_block (largest_block),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.band_a_min    (band_a_min),
		.band_a_max    (band_a_max),
		.band_b_min    (band_b_min),
		.band_b_max    (band_b_max),
		.frag_pct      (frag_pct)
	);

endmodule

`default_nettype wire
